@@ rtl/adaptive_prefetch_boost_controller_assert.svh @@
// assertion macros for the adaptive prefetch boost controller
`ifndef ADAPTIVE_PREFETCH_BOOST_CONTROLLER_ASSERT_SVH
`define ADAPTIVE_PREFETCH_BOOST_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define APBC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define APBC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define APBC_ASSERT_IMP(lbl, ante, cons)
`define APBC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/apbc_pkg.sv @@
// types and constants shared by the prefetch boost controller
package apbc_pkg;

    localparam int DEF_MAX_SAMPLES = 240;
    localparam int DEF_TIME_BITS   = 48;
    localparam int MIN_WINDOW_SAMPLES = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_BACKLOG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SOURCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PROXY   = 3'd4;

    localparam logic [15:0] RST_AGE_LIMIT    = 16'd5000;
    localparam logic [15:0] RST_MIN_INTERVAL = 16'd1200;
    localparam logic [3:0]  RST_BASE_BACKLOG = 4'd2;
    localparam logic [4:0]  RST_BASE_SOURCE  = 5'd4;
    localparam logic [4:0]  RST_BASE_PROXY   = 5'd8;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    localparam logic [1:0] LEVEL_MAX = 2'd3;

    typedef struct packed {
        logic               func;
        logic [47:0]        timestamp_ms;
        logic [7:0]         exact_count;
        logic [7:0]         approx_count;
        logic [7:0]         missing_count;
        logic signed [15:0] frame_lag;
        logic               playing;
        logic [7:0]         decoder_pending;
        logic [7:0]         worker_count;
    } in_t;

    typedef struct packed {
        logic [1:0] boost_level;
        logic [3:0] backlog_limit;
        logic [4:0] source_lookahead;
        logic [4:0] proxy_lookahead;
        logic       level_changed;
    } out_t;

    typedef struct packed {
        logic [15:0] age_limit_ms;
        logic [15:0] min_adjust_interval_ms;
        logic [3:0]  base_backlog_limit;
        logic [4:0]  base_source_lookahead;
        logic [4:0]  base_proxy_lookahead;
    } cfg_t;

    // one stored sample without its time
    typedef struct packed {
        logic               playing;
        logic signed [15:0] frame_lag;
        logic [7:0]         missing_count;
        logic [7:0]         approx_count;
        logic [7:0]         exact_count;
    } sample_t;

    typedef struct packed {
        logic valid;
        logic is_clear;
        in_t  item;
    } fq_head_t;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
    } fq_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STORE,
        ST_PR_RD,
        ST_PR_CMP,
        ST_CHECK,
        ST_SC_RD,
        ST_SC_ACC,
        ST_DECIDE,
        ST_RESULT
    } back_state_t;

endpackage

@@ rtl/adaptive_prefetch_boost_controller.sv @@
// a clear item goes straight to the result; a sample is stored, then the oldest stale entries are pruned
// a due level decision then reads the ring entries in order and updates the level
// the back end takes its next item only after it has registered the result of the last one,
// and a result waits while the previous one is still held for out_ready
// reset: ring empty, level and last change time zero, registers at their defaults
// ring memory contents are not cleared; only entries inside the occupancy are read
module adaptive_prefetch_boost_controller
    import apbc_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int TIME_BITS   = DEF_TIME_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "adaptive_prefetch_boost_controller_assert.svh"

    cfg_t     cfg_reg, cfg_next;
    fq_head_t fq_head;
    fq_stat_t fq_stat;
    logic     fq_pop;
    logic     limits_ok;
    logic     queue_ok;
    logic     take;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_AGE_LIMIT:    cfg_next.age_limit_ms           = cfg_data;
                CFG_MIN_INTERVAL: cfg_next.min_adjust_interval_ms = cfg_data;
                CFG_BASE_BACKLOG: cfg_next.base_backlog_limit     = cfg_data[3:0];
                CFG_BASE_SOURCE:  cfg_next.base_source_lookahead  = cfg_data[4:0];
                CFG_BASE_PROXY:   cfg_next.base_proxy_lookahead   = cfg_data[4:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.age_limit_ms           <= RST_AGE_LIMIT;
            cfg_reg.min_adjust_interval_ms <= RST_MIN_INTERVAL;
            cfg_reg.base_backlog_limit     <= RST_BASE_BACKLOG;
            cfg_reg.base_source_lookahead  <= RST_BASE_SOURCE;
            cfg_reg.base_proxy_lookahead   <= RST_BASE_PROXY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    apbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .head     (fq_head),
        .pop      (fq_pop),
        .stat     (fq_stat)
    );

    apbc_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (fq_head),
        .pop       (fq_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign limits_ok = (out_item.backlog_limit != 4'd0) && (out_item.backlog_limit <= 4'd8) &&
                       (out_item.source_lookahead != 5'd0) &&
                       (out_item.source_lookahead <= 5'd16) &&
                       (out_item.proxy_lookahead != 5'd0) &&
                       (out_item.proxy_lookahead <= 5'd24);
    assign queue_ok  = (fq_stat.count <= 2'd2) && (fq_stat.full == (fq_stat.count == 2'd2));
    assign take      = in_valid && in_ready;

    `APBC_ASSERT_IMP(a_limits_in_range, out_valid, limits_ok)
    `APBC_ASSERT_IMP(a_queue_bound, 1'b1, queue_ok)
    `APBC_ASSERT_NXT(a_pop_drains, fq_pop && !take, fq_stat.count == $past(fq_stat.count) - 2'd1)

endmodule

@@ rtl/apbc_front.sv @@
// front end: accepts items, tags clear requests, two-entry queue to the back end
module apbc_front
    import apbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_t      in_item,
    output fq_head_t head,
    input  logic     pop,
    output fq_stat_t stat
);

    in_t        slot_reg [2];
    logic       clr_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
            clr_reg[wr_ptr_reg]  <= (in_item.func == FUNC_CLEAR);
        end
    end

    assign head.valid    = (count_reg != 2'd0);
    assign head.is_clear = clr_reg[rd_ptr_reg];
    assign head.item     = slot_reg[rd_ptr_reg];
    assign stat.count    = count_reg;
    assign stat.full     = !in_ready;

endmodule

@@ rtl/apbc_back.sv @@
// back end: sample ring, window pruning, window scan and boost level update
module apbc_back
    import apbc_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int TIME_BITS   = DEF_TIME_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  fq_head_t head,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output out_t     out_item
);

    localparam int PTR_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int IW     = CNT_W + 1;
    localparam int SUM_W  = CNT_W + 8;
    localparam int FSUM_W = CNT_W + 16;
    localparam int VW     = SUM_W + 10;

    logic [TIME_BITS-1:0] mem_time [MAX_SAMPLES];
    sample_t              mem_stat [MAX_SAMPLES];

    back_state_t          state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [1:0]           level_reg, level_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [1:0]           before_reg, before_next;
    in_t                  cur_reg, cur_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     w_reg, w_next;
    logic [CNT_W-1:0]     late_reg, late_next;
    logic [SUM_W-1:0]     e_reg, e_next, a_reg, a_next, m_reg, m_next;
    logic signed [FSUM_W-1:0] f_reg, f_next;
    logic                 res_valid_reg, res_valid_next;
    out_t                 res_reg, res_next;

    logic [TIME_BITS-1:0] rd_time_reg;
    sample_t              rd_stat_reg;
    logic [PTR_W-1:0]     rd_addr;
    logic                 we;
    logic [PTR_W-1:0]     wr_addr;

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] win;
    logic                 rd_old;
    logic                 interval_ok;
    logic [IW-1:0]        wr_sum;
    logic [PTR_W:0]       head_inc, ptr_inc;
    logic [PTR_W-1:0]     head_wrap, ptr_wrap;

    logic [VW-1:0]        ve, va, vm, vfs, vav, vw, vl;
    logic signed [VW-1:0] vf, vav8, vav2;
    logic [7:0]           wk;
    logic [6:0]           half;
    logic [7:0]           thr;
    logic                 starved, recovered;

    logic [4:0]           bl_sum;
    logic [5:0]           src_sum, prx_sum;
    out_t                 res_calc;

    assign now  = TIME_BITS'(cur_reg.timestamp_ms);
    assign win  = TIME_BITS'(cfg.age_limit_ms);
    assign rd_old = (now >= win) && (rd_time_reg < (now - win));
    assign interval_ok = (now >= last_reg) &&
                         ((now - last_reg) >= TIME_BITS'(cfg.min_adjust_interval_ms));

    assign wr_sum   = IW'(head_reg) + IW'(occ_reg);
    assign wr_addr  = (wr_sum >= IW'(MAX_SAMPLES)) ? PTR_W'(wr_sum - IW'(MAX_SAMPLES))
                                                  : PTR_W'(wr_sum);
    assign head_inc  = {1'b0, head_reg} + 1'b1;
    assign head_wrap = (head_inc == (PTR_W+1)'(MAX_SAMPLES)) ? '0 : head_inc[PTR_W-1:0];
    assign ptr_inc   = {1'b0, ptr_reg} + 1'b1;
    assign ptr_wrap  = (ptr_inc == (PTR_W+1)'(MAX_SAMPLES)) ? '0 : ptr_inc[PTR_W-1:0];

    assign rd_addr = (state_reg == ST_SC_RD) ? ptr_reg : head_reg;
    assign we      = (state_reg == ST_STORE);

    // verdict terms, exact integer cross products
    always_comb
    begin
        ve   = VW'(e_reg);
        va   = VW'(a_reg);
        vm   = VW'(m_reg);
        vfs  = ve + va + vm;
        vav  = ve + va;
        vw   = VW'(w_reg);
        vl   = VW'(late_reg);
        vf   = VW'(f_reg);
        vav8 = signed'(vav << 3);
        vav2 = signed'(vav << 1);
        wk   = (cur_reg.worker_count == 8'd0) ? 8'd1 : cur_reg.worker_count;
        half = wk[7:1];
        thr  = (half < 7'd2) ? 8'd2 : {1'b0, half};
        starved = (vl * VW'(20) > vw * VW'(7)) ||
                  ((vfs != '0) && (ve * VW'(20) < vfs * VW'(11))) ||
                  ((vav != '0) && (vf > vav8)) ||
                  (cur_reg.decoder_pending >= thr);
        recovered = (vl * VW'(10) < vw) &&
                    ((vfs == '0) || (ve * VW'(10) > vfs * VW'(9))) &&
                    ((vav == '0) || (vf < vav2)) &&
                    (cur_reg.decoder_pending == 8'd0);
    end

    // limits from the current base registers
    always_comb
    begin
        bl_sum  = 5'(cfg.base_backlog_limit) + 5'(level_reg);
        src_sum = 6'(cfg.base_source_lookahead) + 6'({level_reg, 1'b0});
        prx_sum = 6'(cfg.base_proxy_lookahead) + 6'({level_reg, 1'b0});
        res_calc.boost_level = level_reg;
        res_calc.backlog_limit = (bl_sum == 5'd0) ? 4'd1 :
                                 (bl_sum > 5'd8) ? 4'd8 : bl_sum[3:0];
        res_calc.source_lookahead = (src_sum == 6'd0) ? 5'd1 :
                                    (src_sum > 6'd16) ? 5'd16 : src_sum[4:0];
        res_calc.proxy_lookahead = (prx_sum == 6'd0) ? 5'd1 :
                                   (prx_sum > 6'd24) ? 5'd24 : prx_sum[4:0];
        res_calc.level_changed = (level_reg != before_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        level_next     = level_reg;
        last_next      = last_reg;
        before_next    = before_reg;
        cur_next       = cur_reg;
        ptr_next       = ptr_reg;
        k_next         = k_reg;
        w_next         = w_reg;
        late_next      = late_reg;
        e_next         = e_reg;
        a_next         = a_reg;
        m_next         = m_reg;
        f_next         = f_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        pop            = 1'b0;

        if (res_valid_reg && out_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop         = 1'b1;
                    cur_next    = head.item;
                    before_next = level_reg;
                    if (head.is_clear)
                    begin
                        head_next  = '0;
                        occ_next   = '0;
                        level_next = '0;
                        last_next  = '0;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_STORE;
                    end
                end
            end
            ST_STORE:
            begin
                if (occ_reg < CNT_W'(MAX_SAMPLES))
                begin
                    occ_next = occ_reg + 1'b1;
                end
                else
                begin
                    head_next = head_wrap;
                end
                state_next = ST_PR_RD;
            end
            ST_PR_RD:
            begin
                state_next = (occ_reg == '0) ? ST_CHECK : ST_PR_CMP;
            end
            ST_PR_CMP:
            begin
                if (rd_old)
                begin
                    head_next  = head_wrap;
                    occ_next   = occ_reg - 1'b1;
                    state_next = ST_PR_RD;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                ptr_next  = head_reg;
                k_next    = '0;
                w_next    = '0;
                late_next = '0;
                e_next    = '0;
                a_next    = '0;
                m_next    = '0;
                f_next    = '0;
                state_next = (cur_reg.playing && interval_ok) ? ST_SC_RD : ST_RESULT;
            end
            ST_SC_RD:
            begin
                state_next = (k_reg == occ_reg) ? ST_DECIDE : ST_SC_ACC;
            end
            ST_SC_ACC:
            begin
                if (rd_stat_reg.playing && !rd_old)
                begin
                    w_next = w_reg + 1'b1;
                    e_next = e_reg + SUM_W'(rd_stat_reg.exact_count);
                    a_next = a_reg + SUM_W'(rd_stat_reg.approx_count);
                    m_next = m_reg + SUM_W'(rd_stat_reg.missing_count);
                    f_next = f_reg + FSUM_W'(rd_stat_reg.frame_lag);
                    if (rd_stat_reg.frame_lag > 16'sd0)
                    begin
                        late_next = late_reg + 1'b1;
                    end
                end
                ptr_next   = ptr_wrap;
                k_next     = k_reg + 1'b1;
                state_next = ST_SC_RD;
            end
            ST_DECIDE:
            begin
                if (w_reg >= CNT_W'(MIN_WINDOW_SAMPLES))
                begin
                    if (starved && (level_reg != LEVEL_MAX))
                    begin
                        level_next = level_reg + 1'b1;
                        last_next  = now;
                    end
                    else if (recovered && (level_reg != 2'd0))
                    begin
                        level_next = level_reg - 1'b1;
                        last_next  = now;
                    end
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!res_valid_reg || out_ready)
                begin
                    res_valid_next = 1'b1;
                    res_next       = res_calc;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            level_reg     <= '0;
            last_reg      <= '0;
            before_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            level_reg     <= level_next;
            last_reg      <= last_next;
            before_reg    <= before_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        ptr_reg  <= ptr_next;
        k_reg    <= k_next;
        w_reg    <= w_next;
        late_reg <= late_next;
        e_reg    <= e_next;
        a_reg    <= a_next;
        m_reg    <= m_next;
        f_reg    <= f_next;
        res_reg  <= res_next;
    end

    // sample ring memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_time[wr_addr] <= now;
            mem_stat[wr_addr] <= {cur_reg.playing, cur_reg.frame_lag, cur_reg.missing_count,
                                  cur_reg.approx_count, cur_reg.exact_count};
        end
        rd_time_reg <= mem_time[rd_addr];
        rd_stat_reg <= mem_stat[rd_addr];
    end

    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for the adaptive prefetch boost controller
`timescale 1ns / 100ps

module testbench;
    import apbc_pkg::*;

    localparam int RING_DEPTH  = DEF_MAX_SAMPLES;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int PHASE_ITEMS = 250;

    class boost_scoreboard;
        logic [47:0] ring_time [RING_DEPTH];
        sample_t     ring_stat [RING_DEPTH];
        int          head;
        int          occupancy;
        int          level;
        logic [47:0] last_change_ms;
        int          age_limit_ms;
        int          min_interval_ms;
        int          base_backlog;
        int          base_source;
        int          base_proxy;
        out_t        expected_results [$];
        int          errors;

        function new();
            head = 0;
            occupancy = 0;
            level = 0;
            last_change_ms = '0;
            age_limit_ms = RST_AGE_LIMIT;
            min_interval_ms = RST_MIN_INTERVAL;
            base_backlog = RST_BASE_BACKLOG;
            base_source = RST_BASE_SOURCE;
            base_proxy = RST_BASE_PROXY;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_AGE_LIMIT:    age_limit_ms = data;
                CFG_MIN_INTERVAL: min_interval_ms = data;
                CFG_BASE_BACKLOG: base_backlog = data[3:0];
                CFG_BASE_SOURCE:  base_source = data[4:0];
                CFG_BASE_PROXY:   base_proxy = data[4:0];
                default: ;
            endcase
        endfunction

        function bit is_stale(logic [47:0] ts, logic [47:0] now);
            return now >= 48'(age_limit_ms) && ts < now - 48'(age_limit_ms);
        endfunction

        function int clamp(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void judge_window(logic [47:0] now, int pending, int workers);
            longint w, e, a, m, late, f, fs, av;
            int idx, wk, thr;
            bit starved, recovered;
            w = 0; e = 0; a = 0; m = 0; late = 0; f = 0;
            if (now < last_change_ms || now - last_change_ms < 48'(min_interval_ms))
                return;
            for (int k = 0; k < occupancy; k++)
            begin
                idx = (head + k) % RING_DEPTH;
                if (!ring_stat[idx].playing || is_stale(ring_time[idx], now))
                    continue;
                w++;
                e += ring_stat[idx].exact_count;
                a += ring_stat[idx].approx_count;
                m += ring_stat[idx].missing_count;
                f += ring_stat[idx].frame_lag;
                if (ring_stat[idx].frame_lag > 0)
                    late++;
            end
            if (w < MIN_WINDOW_SAMPLES)
                return;
            fs = e + a + m;
            av = e + a;
            wk = workers < 1 ? 1 : workers;
            thr = wk / 2 < 2 ? 2 : wk / 2;
            starved = 20 * late > 7 * w || (fs > 0 && 20 * e < 11 * fs) ||
                      (av > 0 && f > 8 * av) || pending >= thr;
            recovered = 10 * late < w && (fs == 0 || 10 * e > 9 * fs) &&
                        (av == 0 || f < 2 * av) && pending == 0;
            if (starved && level < LEVEL_MAX)
                level++;
            else if (recovered && level > 0)
                level--;
            else
                return;
            last_change_ms = now;
        endfunction

        function void note_input(in_t it);
            int prior, idx;
            out_t r;
            prior = level;
            if (it.func == FUNC_CLEAR)
            begin
                head = 0;
                occupancy = 0;
                level = 0;
                last_change_ms = '0;
            end
            else
            begin
                idx = (head + occupancy) % RING_DEPTH;
                ring_time[idx] = it.timestamp_ms;
                ring_stat[idx] = '{it.playing, it.frame_lag, it.missing_count,
                                   it.approx_count, it.exact_count};
                if (occupancy < RING_DEPTH)
                    occupancy++;
                else
                    head = (head + 1) % RING_DEPTH;
                while (occupancy > 0 && is_stale(ring_time[head], it.timestamp_ms))
                begin
                    head = (head + 1) % RING_DEPTH;
                    occupancy--;
                end
                if (it.playing)
                    judge_window(it.timestamp_ms, it.decoder_pending, it.worker_count);
            end
            r.boost_level = 2'(level);
            r.backlog_limit = 4'(clamp(base_backlog + level, 1, 8));
            r.source_lookahead = 5'(clamp(base_source + 2 * level, 1, 16));
            r.proxy_lookahead = 5'(clamp(base_proxy + 2 * level, 1, 24));
            r.level_changed = level != prior;
            expected_results = {expected_results, r};
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_results.size() == 0)
            begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.boost_level !== want.boost_level)
            begin
                $error("boost_level expected %0d got %0d", want.boost_level, got.boost_level);
                errors++;
            end
            if (got.backlog_limit !== want.backlog_limit)
            begin
                $error("backlog_limit expected %0d got %0d",
                       want.backlog_limit, got.backlog_limit);
                errors++;
            end
            if (got.source_lookahead !== want.source_lookahead)
            begin
                $error("source_lookahead expected %0d got %0d",
                       want.source_lookahead, got.source_lookahead);
                errors++;
            end
            if (got.proxy_lookahead !== want.proxy_lookahead)
            begin
                $error("proxy_lookahead expected %0d got %0d",
                       want.proxy_lookahead, got.proxy_lookahead);
                errors++;
            end
            if (got.level_changed !== want.level_changed)
            begin
                $error("level_changed expected %0d got %0d",
                       want.level_changed, got.level_changed);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    boost_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int burst_left = 0;
    logic [47:0] now_ms;

    adaptive_prefetch_boost_controller dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall pattern cycles through free-running, random and periodic
    always @(posedge clk)
    begin
        case ((cycle_count >> 11) % 3)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 9) < 7);
            default: out_ready <= (cycle_count % 7) < 3;
        endcase
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);

    task automatic send_item(in_t it);
        int gap;
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_input(it);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic in_t make_clear();
        in_t it;
        it = in_t'({$urandom, $urandom, $urandom, $urandom});
        it.func = FUNC_CLEAR;
        return it;
    endfunction

    // healthy playback sample when good is set, struggling otherwise
    function automatic in_t make_sample(logic [47:0] ts, bit good);
        in_t it;
        it.func = FUNC_SAMPLE;
        it.timestamp_ms = ts;
        it.playing = 1'b1;
        it.worker_count = 8'($urandom_range(0, 8));
        if (good)
        begin
            it.exact_count = 8'($urandom_range(1, 255));
            it.approx_count = $urandom_range(0, 3) == 0 ? 8'd1 : 8'd0;
            it.missing_count = 8'd0;
            it.frame_lag = $urandom_range(0, 9) == 0 ? 16'sd1 :
                           -$signed(16'($urandom_range(0, 4)));
            it.decoder_pending = $urandom_range(0, 7) == 0 ? 8'd1 : 8'd0;
        end
        else
        begin
            it.exact_count = 8'($urandom_range(0, 40));
            it.approx_count = 8'($urandom_range(0, 255));
            it.missing_count = 8'($urandom_range(0, 255));
            it.frame_lag = $urandom_range(0, 3) == 0 ? 16'sd32767 :
                           $signed(16'($urandom_range(0, 60)));
            it.decoder_pending = 8'($urandom_range(0, 255));
        end
        return it;
    endfunction

    task automatic run_phase(int window, int interval, int items);
        int step_max, run_left;
        bit good;
        in_t it;
        write_reg(CFG_AGE_LIMIT, 16'(window));
        write_reg(CFG_MIN_INTERVAL, 16'(interval));
        write_reg(CFG_BASE_BACKLOG, 16'($urandom));
        write_reg(CFG_BASE_SOURCE, 16'($urandom));
        write_reg(CFG_BASE_PROXY, 16'($urandom));
        step_max = window / 40 + 1;
        now_ms = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
        send_item(make_clear());
        run_left = 0;
        good = 1'b0;
        for (int n = 0; n < items; n++)
        begin
            if (n == items / 2 && $urandom_range(0, 1))
                wait_drained();
            if (run_left == 0)
            begin
                run_left = $urandom_range(10, 80);
                good = 1'($urandom_range(0, 1));
            end
            run_left--;
            now_ms = now_ms + 48'($urandom_range(0, step_max));
            case ($urandom_range(0, 99))
                0, 1: it = make_clear();
                2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                begin
                    it = in_t'({$urandom, $urandom, $urandom, $urandom});
                    it.func = FUNC_SAMPLE;
                    // mostly stepped back up to two windows from current time, otherwise a random time
                    if ($urandom_range(0, 3) != 0)
                        it.timestamp_ms = now_ms - 48'($urandom_range(0, 2 * window));
                end
                default: it = make_sample(now_ms, good);
            endcase
            send_item(it);
        end
        wait_drained();
    endtask

    initial
    begin
        in_t it;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes under reset registers
        it = '0;
        send_item(it);
        it = '1;
        it.func = FUNC_SAMPLE;
        send_item(it);
        it.frame_lag = 16'sh8000;
        it.playing = 1'b0;
        send_item(it);
        it = make_sample(48'd100, 1'b0);
        it.worker_count = 8'd0;
        it.decoder_pending = 8'd2;
        send_item(it);
        it = make_sample(48'd50, 1'b1);
        send_item(it);
        send_item(make_clear());
        for (int n = 0; n < 30; n++)
            send_item(make_sample(48'(1300 + 10 * n), 1'b0));
        send_item(make_clear());
        wait_drained();

        // register extremes, then random settings
        run_phase(1, 0, 150);
        run_phase(65535, 65535, 200);
        write_reg(CFG_BASE_BACKLOG, 16'd0);
        run_phase(5000, 0, 200);
        run_phase(2000, 300, PHASE_ITEMS);
        run_phase(65535, 0, 150);
        run_phase($urandom_range(1, 65535), $urandom_range(0, 3000), PHASE_ITEMS);
        run_phase($urandom_range(500, 8000), $urandom_range(0, 1500), PHASE_ITEMS);
        run_phase($urandom_range(1, 65535), $urandom_range(0, 65535), PHASE_ITEMS);
        run_phase($urandom_range(300, 6000), $urandom_range(0, 800), PHASE_ITEMS);

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
